// ===== rtl/core/gisc_pkg.sv =====
// Shared types and constants of the gray image stream checker.
package gisc_pkg;

	localparam int WORD_W = 32;

	// Magic bytes 'P' and '5'
	localparam logic [7:0] MAGIC_FIRST  = 8'h50;
	localparam logic [7:0] MAGIC_SECOND = 8'h35;

	// Result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
	localparam logic [2:0] ST_TRUNCATED  = 3'd2;
	localparam logic [2:0] ST_OVER_LIMIT = 3'd3;
	localparam logic [2:0] ST_MISMATCH   = 3'd4;
	localparam logic [2:0] ST_FLAT       = 3'd5;

	typedef enum logic [2:0] {
		PH_MAGIC0,
		PH_MAGIC1,
		PH_DIMS,
		PH_LIMIT,
		PH_PIXELS,
		PH_SKIP,
		PH_FIN_START,
		PH_FIN_WAIT
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_DIMS,
		OP_LIMIT,
		OP_PIXEL
	} byte_op_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [WORD_W-1:0] image_width;
		logic [WORD_W-1:0] image_height;
		logic [WORD_W-1:0] pixel_limit;
		logic [WORD_W-1:0] pixel_total;
		logic [7:0]        lowest_pixel;
		logic [7:0]        highest_pixel;
		logic [7:0]        average_pixel;
	} result_item_t;

	// Controller to datapath
	typedef struct packed {
		byte_op_t   op;
		logic [2:0] set_err;
		logic       fin_start;
		logic       load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic magic0_ok;
		logic magic1_ok;
		logic word_done;
		logic dims_done;
		logic over_limit;
		logic div_busy;
	} dp_stat_t;

endpackage

// ===== rtl/core/gray_image_stream_checker.sv =====
// Top level of the gray image stream checker.
// Takes a binary gray image file one byte item per cycle unless stalled: magic 'P'
// '5', big-endian header words (width and height, zero words skipped, then the
// pixel limit), then pixel bytes. Every byte, including the one marked end_of_file,
// is taken whenever byte_stall is low. After the end-of-file byte the byte input
// stalls while the expected count is multiplied out and the bit-serial divider
// forms the mean, one quotient bit per cycle, and while an earlier result item is
// still waiting in the output register. The result item then sits in that
// register, and the next file may start while it waits to be taken. Only the
// end-of-file byte produces a result item; the parser then returns to its reset state.
module gray_image_stream_checker import gisc_pkg::*; #(
	parameter int HEADER_WORD_BYTES = 4,
	parameter int SUM_BITS          = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_stall,
	input  byte_item_t   byte_item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_item
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gisc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.end_of_file (byte_item.end_of_file),
		.byte_stall  (byte_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	gisc_dp #(
		.HEADER_WORD_BYTES(HEADER_WORD_BYTES),
		.SUM_BITS         (SUM_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_byte(byte_item.data_byte),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result_item)
	);

endmodule

// ===== rtl/core/gisc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module gisc_div #(
	parameter int DIVIDEND_W = 40,
	parameter int DIVISOR_W  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CntW = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [CntW-1:0]       cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;
	logic [DIVISOR_W-1:0]  rem_d;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
		rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CntW'(1);
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/gisc_dp.sv =====
// Datapath: header word assembly, pixel statistics, final checks and result register.
module gisc_dp import gisc_pkg::*; #(
	parameter int HEADER_WORD_BYTES = 4,
	parameter int SUM_BITS          = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   data_byte,
	input  dp_cmd_t      cmd,
	output dp_stat_t     stat,
	output result_item_t result
);

	localparam int CntW = (HEADER_WORD_BYTES > 1) ? $clog2(HEADER_WORD_BYTES) : 1;
	localparam logic [CntW-1:0] LastByte = CntW'(HEADER_WORD_BYTES - 1);

	logic [CntW-1:0]     wcnt_q;
	logic [WORD_W-1:0]   word_q;
	logic [WORD_W-1:0]   width_q;
	logic [WORD_W-1:0]   height_q;
	logic [WORD_W-1:0]   limit_q;
	logic [WORD_W-1:0]   count_q;
	logic [7:0]          min_q;
	logic [7:0]          max_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [2:0]          err_q;
	logic [2*WORD_W-1:0] prod_q;
	result_item_t        result_q;

	logic [WORD_W-1:0]   word_v;
	logic                word_last;
	logic [WORD_W-1:0]   new_w;
	logic [WORD_W-1:0]   new_h;
	logic                over;
	logic                div_busy;
	logic [SUM_BITS-1:0] quo;
	logic [2*WORD_W-1:0] prod_d;
	logic                has_pix;
	result_item_t        result_d;

	// Header word and pixel checks on the current byte
	always_comb begin
		word_v    = {word_q[WORD_W-9:0], data_byte};
		word_last = wcnt_q == LastByte;
		new_w     = (width_q == '0) ? word_v : width_q;
		new_h     = (width_q == '0) ? height_q : word_v;
		over      = {{(WORD_W-8){1'b0}}, data_byte} > limit_q;
	end

	assign stat.magic0_ok  = data_byte == MAGIC_FIRST;
	assign stat.magic1_ok  = data_byte == MAGIC_SECOND;
	assign stat.word_done  = word_last;
	assign stat.dims_done  = (new_w != '0) && (new_h != '0);
	assign stat.over_limit = over;
	assign stat.div_busy   = div_busy;

	// Parse state; cleared when a result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q   <= '0;
			word_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			limit_q  <= '0;
			count_q  <= '0;
			min_q    <= 8'hFF;
			max_q    <= '0;
			sum_q    <= '0;
			err_q    <= ST_OK;
		end else if (cmd.load_out) begin
			wcnt_q   <= '0;
			word_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			limit_q  <= '0;
			count_q  <= '0;
			min_q    <= 8'hFF;
			max_q    <= '0;
			sum_q    <= '0;
			err_q    <= ST_OK;
		end else begin
			if (cmd.set_err != ST_OK) begin
				err_q <= cmd.set_err;
			end
			unique case (cmd.op)
				OP_DIMS, OP_LIMIT: begin
					if (word_last) begin
						wcnt_q <= '0;
						word_q <= '0;
						if (cmd.op == OP_DIMS) begin
							width_q  <= new_w;
							height_q <= new_h;
						end else begin
							limit_q <= word_v;
							min_q   <= 8'hFF;
						end
					end else begin
						wcnt_q <= wcnt_q + CntW'(1);
						word_q <= word_v;
					end
				end
				OP_PIXEL: begin
					if (!over) begin
						// count saturates, and the sum freezes with it
						if (count_q != '1) begin
							count_q <= count_q + WORD_W'(1);
							sum_q   <= sum_q + SUM_BITS'(data_byte);
						end
						if (data_byte < min_q) begin
							min_q <= data_byte;
						end
						if (data_byte > max_q) begin
							max_q <= data_byte;
						end
					end
				end
				OP_NONE: begin
				end
			endcase
		end
	end

	// Mean of the pixels
	gisc_div #(
		.DIVIDEND_W(SUM_BITS),
		.DIVISOR_W (WORD_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.fin_start),
		.dividend(sum_q),
		.divisor (count_q),
		.busy    (div_busy),
		.quotient(quo)
	);

	assign prod_d = (2*WORD_W)'(width_q) * (2*WORD_W)'(height_q);

	// Expected pixel count
	always_ff @(posedge clk) begin
		if (cmd.fin_start) begin
			prod_q <= prod_d;
		end
	end

	// Result fields and status priority
	always_comb begin
		has_pix                = count_q != '0;
		result_d.image_width   = width_q;
		result_d.image_height  = height_q;
		result_d.pixel_limit   = limit_q;
		result_d.pixel_total   = count_q;
		result_d.lowest_pixel  = has_pix ? min_q : 8'h00;
		result_d.highest_pixel = has_pix ? max_q : 8'h00;
		if (!has_pix) begin
			result_d.average_pixel = 8'h00;
		end else if (|quo[SUM_BITS-1:8]) begin
			result_d.average_pixel = 8'hFF;
		end else begin
			result_d.average_pixel = quo[7:0];
		end
		priority if (err_q != ST_OK) begin
			result_d.status = err_q;
		end else if ({{WORD_W{1'b0}}, count_q} != prod_q) begin
			result_d.status = ST_MISMATCH;
		end else if (min_q == max_q) begin
			result_d.status = ST_FLAT;
		end else begin
			result_d.status = ST_OK;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q <= result_d;
		end
	end

	assign result = result_q;

endmodule

// ===== rtl/core/gisc_ctrl.sv =====
// Controller: parse phase state machine, end-of-file sequence and output valid.
module gisc_ctrl import gisc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	input  logic     end_of_file,
	output logic     byte_stall,
	output logic     result_valid,
	input  logic     result_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	phase_t state_q;
	phase_t state_d;
	logic   out_vld_q;
	logic   out_vld_d;
	logic   accept;

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= PH_MAGIC0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_vld_q <= out_vld_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		out_vld_d     = out_vld_q && result_stall;
		cmd.op        = OP_NONE;
		cmd.set_err   = ST_OK;
		cmd.fin_start = 1'b0;
		cmd.load_out  = 1'b0;
		byte_stall    = (state_q == PH_FIN_START) || (state_q == PH_FIN_WAIT);
		accept        = byte_valid && !byte_stall;

		unique case (state_q)
			PH_MAGIC0: begin
				if (accept) begin
					if (stat.magic0_ok) begin
						state_d = PH_MAGIC1;
					end else begin
						cmd.set_err = ST_BAD_MAGIC;
						state_d     = PH_SKIP;
					end
				end
			end
			PH_MAGIC1: begin
				if (accept) begin
					if (stat.magic1_ok) begin
						state_d = PH_DIMS;
					end else begin
						cmd.set_err = ST_BAD_MAGIC;
						state_d     = PH_SKIP;
					end
				end
			end
			PH_DIMS: begin
				if (accept) begin
					cmd.op = OP_DIMS;
					if (stat.word_done && stat.dims_done) begin
						state_d = PH_LIMIT;
					end
				end
			end
			PH_LIMIT: begin
				if (accept) begin
					cmd.op = OP_LIMIT;
					if (stat.word_done) begin
						state_d = PH_PIXELS;
					end
				end
			end
			PH_PIXELS: begin
				if (accept) begin
					cmd.op = OP_PIXEL;
					if (stat.over_limit) begin
						cmd.set_err = ST_OVER_LIMIT;
						state_d     = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
			end
			PH_FIN_START: begin
				cmd.fin_start = 1'b1;
				state_d       = PH_FIN_WAIT;
			end
			PH_FIN_WAIT: begin
				// hand over once the mean is ready and the output register is free
				if (!stat.div_busy && (!out_vld_q || !result_stall)) begin
					cmd.load_out = 1'b1;
					out_vld_d    = 1'b1;
					state_d      = PH_MAGIC0;
				end
			end
		endcase

		// Last byte of the file: header cut short unless an error is already set
		if (accept && end_of_file) begin
			if (cmd.set_err == ST_OK &&
			    (state_d == PH_MAGIC0 || state_d == PH_MAGIC1 ||
			     state_d == PH_DIMS || state_d == PH_LIMIT)) begin
				cmd.set_err = ST_TRUNCATED;
			end
			state_d = PH_FIN_START;
		end
	end

	assign result_valid = out_vld_q;

endmodule

// ===== verif/gray_image_stream_checker_tb.sv =====
// Self-checking testbench for the gray image stream checker: directed and random image files.
module gray_image_stream_checker_tb import gisc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HDR_BYTES   = 4;
	localparam int SUM_W       = 40;
	localparam int ITEM_TARGET = 1750;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 400000;

	// One line of the directed table; result is only used where fixed is set
	typedef struct packed {
		logic [7:0]   data_byte;
		logic         end_of_file;
		logic         fixed;
		result_item_t result;
	} directed_row_t;

	// Directed files: bad magic on either byte, a cut header, then a header with
	// all-ones dimensions, a skipped zero word and a pixel above the limit.
	localparam directed_row_t DIRECTED_ROWS [25] = '{
		'{MAGIC_FIRST, 1'b0, 1'b0, '0},
		'{8'h36, 1'b1, 1'b1, '{ST_BAD_MAGIC, '0, '0, '0, '0, '0, '0, '0}},
		'{8'h51, 1'b1, 1'b1, '{ST_BAD_MAGIC, '0, '0, '0, '0, '0, '0, '0}},
		'{MAGIC_FIRST, 1'b1, 1'b1, '{ST_TRUNCATED, '0, '0, '0, '0, '0, '0, '0}},
		'{MAGIC_FIRST, 1'b0, 1'b0, '0},
		'{MAGIC_SECOND, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFE, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h7F, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b1, '{ST_OVER_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_00FE,
			32'd2, 8'h00, 8'h7F, 8'h3F}}
	};

	logic         clk;
	logic         arst_n;
	logic         byte_valid;
	logic         byte_stall;
	byte_item_t   byte_item;
	logic         result_valid;
	logic         result_stall;
	result_item_t result_item;

	// Parser state tracked alongside the block
	phase_t            pred_phase;
	int                hdr_count;
	logic [31:0]       hdr_word;
	logic [31:0]       img_w;
	logic [31:0]       img_h;
	logic [31:0]       img_limit;
	logic [31:0]       pix_count;
	logic [31:0]       pix_min;
	logic [7:0]        pix_max;
	logic [SUM_W-1:0]  pix_sum;
	logic [2:0]        pred_err;

	result_item_t awaited_reports [$];
	byte_item_t   file_bytes [$];

	int  fail_count    = 0;
	int  parsed_bytes  = 0;
	int  images_sent   = 0;
	int  reports_seen  = 0;
	int  status_seen [6];
	int  cycle_count   = 0;
	int  send_idle_pct = 13;
	int  recv_idle_pct = 72;
	bit  hold_request  = 1'b0;

	gray_image_stream_checker #(
		.HEADER_WORD_BYTES(HDR_BYTES),
		.SUM_BITS(SUM_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_parse_state();
		pred_phase = PH_MAGIC0;
		hdr_count  = 0;
		hdr_word   = '0;
		img_w      = '0;
		img_h      = '0;
		img_limit  = '0;
		pix_count  = '0;
		pix_min    = '0;
		pix_max    = '0;
		pix_sum    = '0;
		pred_err   = ST_OK;
	endfunction

	// Advance the parser by one byte; on end of file, form the image report
	function automatic void parse_file_byte(input byte_item_t it, output bit emitted,
			output result_item_t rep);
		logic [63:0] product;
		logic [63:0] mean;
		emitted = 1'b0;
		rep = '0;
		case (pred_phase)
			PH_MAGIC0: begin
				if (it.data_byte != MAGIC_FIRST) begin
					pred_err = ST_BAD_MAGIC;
					pred_phase = PH_SKIP;
				end else
					pred_phase = PH_MAGIC1;
			end
			PH_MAGIC1: begin
				if (it.data_byte != MAGIC_SECOND) begin
					pred_err = ST_BAD_MAGIC;
					pred_phase = PH_SKIP;
				end else begin
					pred_phase = PH_DIMS;
					hdr_count = 0;
					hdr_word = '0;
				end
			end
			PH_DIMS, PH_LIMIT: begin
				// only the low 32 bits of a header word survive
				hdr_word = {hdr_word[23:0], it.data_byte};
				hdr_count++;
				if (hdr_count == HDR_BYTES) begin
					hdr_count = 0;
					if (pred_phase == PH_DIMS) begin
						if (img_w == '0)
							img_w = hdr_word;
						else
							img_h = hdr_word;
						if (img_w != '0 && img_h != '0)
							pred_phase = PH_LIMIT;
					end else begin
						img_limit = hdr_word;
						pix_min = hdr_word;
						pred_phase = PH_PIXELS;
					end
					hdr_word = '0;
				end
			end
			PH_PIXELS: begin
				if (32'(it.data_byte) > img_limit) begin
					pred_err = ST_OVER_LIMIT;
					pred_phase = PH_SKIP;
				end else begin
					// count saturates and the sum freezes with it
					if (pix_count != '1) begin
						pix_count++;
						pix_sum = pix_sum + SUM_W'(it.data_byte);
					end
					if (32'(it.data_byte) < pix_min)
						pix_min = 32'(it.data_byte);
					if (it.data_byte > pix_max)
						pix_max = it.data_byte;
				end
			end
			default: ;
		endcase

		if (it.end_of_file) begin
			if (pred_err == ST_OK && pred_phase < PH_PIXELS)
				pred_err = ST_TRUNCATED;
			product = 64'(img_w) * 64'(img_h);
			rep.image_width  = img_w;
			rep.image_height = img_h;
			rep.pixel_limit  = img_limit;
			rep.pixel_total  = pix_count;
			if (pix_count != '0) begin
				mean = 64'(pix_sum) / 64'(pix_count);
				rep.lowest_pixel  = pix_min[7:0];
				rep.highest_pixel = pix_max;
				rep.average_pixel = (mean > 64'd255) ? 8'hFF : mean[7:0];
			end
			// latched error first, then count, then flat
			if (pred_err != ST_OK)
				rep.status = pred_err;
			else if (64'(pix_count) != product)
				rep.status = ST_MISMATCH;
			else if (pix_min == 32'(pix_max))
				rep.status = ST_FLAT;
			else
				rep.status = ST_OK;
			emitted = 1'b1;
			clear_parse_state();
		end
	endfunction

	// Offer one byte item, wait for it to be taken, then update the parser
	task automatic send_byte(input byte_item_t it, input bit fixed, input result_item_t fixed_rep);
		bit           emitted;
		result_item_t rep;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		do
			@(posedge clk);
		while (byte_stall);
		parsed_bytes++;
		parse_file_byte(it, emitted, rep);
		if (emitted) begin
			awaited_reports = {awaited_reports, (fixed ? fixed_rep : rep)};
			images_sent++;
		end
	endtask

	function automatic void add_byte(input logic [7:0] b);
		byte_item_t it;
		it.data_byte = b;
		it.end_of_file = 1'b0;
		file_bytes = {file_bytes, it};
	endfunction

	// Big-endian header word, padded with leading zero bytes when words are wider
	function automatic void push_word(input logic [31:0] w);
		logic [63:0] wide;
		wide = 64'(w);
		for (int i = HDR_BYTES - 1; i >= 0; i--)
			add_byte(wide[8*i +: 8]);
	endfunction

	// Zero words in the dimension field are skipped by the parser
	function automatic void push_zero_words();
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) push_word('0);
	endfunction

	function automatic logic [31:0] pick_dim();
		logic [31:0] d;
		if ($urandom_range(9) == 0) begin
			d = $urandom;
			if (d == '0)
				d = 32'd1;
		end else
			d = $urandom_range(1, 6);
		return d;
	endfunction

	// Random file: mostly well-formed images, some over the limit, cut short,
	// with a broken magic, or plain noise
	task automatic build_random_image();
		int          kind;
		int          cap;
		int          npix;
		int          bad_at;
		bit          flat;
		logic [7:0]  flat_val;
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] lim;
		logic [63:0] product;
		file_bytes.delete();
		kind = $urandom_range(99);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
		end else if (kind >= 80) begin
			if ($urandom_range(1)) begin
				add_byte(MAGIC_FIRST);
				add_byte(MAGIC_SECOND ^ 8'($urandom_range(1, 255)));
			end else
				add_byte(MAGIC_FIRST ^ 8'($urandom_range(1, 255)));
			repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
		end else begin
			add_byte(MAGIC_FIRST);
			add_byte(MAGIC_SECOND);
			push_zero_words();
			w = pick_dim();
			push_word(w);
			push_zero_words();
			h = pick_dim();
			push_word(h);
			case ($urandom_range(3))
				0: lim = 32'd255;
				3: lim = $urandom;
				default: lim = $urandom_range(0, 255);
			endcase
			if (kind >= 60 && kind < 70 && lim >= 32'd255)
				lim = $urandom_range(0, 254);
			push_word(lim);
			if (kind >= 70) begin
				// header cut anywhere, up to its full length
				npix = $urandom_range(1, file_bytes.size());
				while (file_bytes.size() > npix)
					void'(file_bytes.pop_back());
			end else begin
				cap = (lim > 32'd255) ? 255 : int'(lim);
				product = 64'(w) * 64'(h);
				if (product <= 64'd36) begin
					npix = int'(product);
					if ($urandom_range(7) == 0)
						npix = $urandom_range(1) ? npix + 1 : npix - 1;
				end else
					npix = $urandom_range(0, 8);
				flat = ($urandom_range(5) == 0);
				flat_val = 8'($urandom_range(0, cap));
				bad_at = (kind >= 60) ? $urandom_range(0, npix) : -1;
				for (int i = 0; i <= npix; i++) begin
					if (i == bad_at)
						add_byte(8'($urandom_range(cap + 1, 255)));
					if (i < npix)
						add_byte(flat ? flat_val : 8'($urandom_range(0, cap)));
				end
			end
		end
		file_bytes[$].end_of_file = 1'b1;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("[%0t] report %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
		end
	endtask

	task automatic take_report(input result_item_t got);
		result_item_t want;
		if (got.status <= ST_FLAT)
			status_seen[got.status]++;
		reports_seen++;
		if (awaited_reports.size() == 0) begin
			fail_count++;
			$display("[%0t] report with none awaited: expected nothing, actual %p", $time, got);
		end else begin
			want = awaited_reports.pop_front();
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("image_width", want.image_width, got.image_width);
			check_field("image_height", want.image_height, got.image_height);
			check_field("pixel_limit", want.pixel_limit, got.pixel_limit);
			check_field("pixel_total", want.pixel_total, got.pixel_total);
			check_field("lowest_pixel", 32'(want.lowest_pixel), 32'(got.lowest_pixel));
			check_field("highest_pixel", 32'(want.highest_pixel), 32'(got.highest_pixel));
			check_field("average_pixel", 32'(want.average_pixel), 32'(got.average_pixel));
		end
	endtask

	// Report sink: random stall, plus one long hold-off when requested
	initial begin : report_sink
		int hold_left;
		bit hold_served;
		hold_left = 0;
		hold_served = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				take_report(result_item);
			if (hold_request && !hold_served) begin
				hold_left = HOLD_CYCLES;
				hold_served = 1'b1;
			end
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else
				result_stall <= (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("gray_image_stream_checker verification failed");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		byte_item_t row_item;
		int         stage;
		stage = 0;
		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		byte_item  <= '0;
		clear_parse_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			row_item.data_byte   = DIRECTED_ROWS[r].data_byte;
			row_item.end_of_file = DIRECTED_ROWS[r].end_of_file;
			send_byte(row_item, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].result);
		end

		while (parsed_bytes < ITEM_TARGET) begin
			// swap idling sides, then run flat out with one long report hold-off
			if (stage == 0 && parsed_bytes >= ITEM_TARGET / 3) begin
				stage = 1;
				send_idle_pct = 72;
				recv_idle_pct <= 13;
			end else if (stage == 1 && parsed_bytes >= 2 * ITEM_TARGET / 3) begin
				stage = 2;
				send_idle_pct = 0;
				recv_idle_pct <= 0;
				hold_request <= 1'b1;
			end
			build_random_image();
			foreach (file_bytes[i])
				send_byte(file_bytes[i], 1'b0, '0);
		end
		byte_valid <= 1'b0;

		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SUM_W + 16) @(posedge clk);

		$display("Parsed %0d byte items over %0d image files; %0d reports checked.",
			parsed_bytes, images_sent, reports_seen);
		$display("Status mix: ok %0d, bad magic %0d, truncated %0d, over limit %0d, %s %0d, flat %0d",
			status_seen[ST_OK], status_seen[ST_BAD_MAGIC], status_seen[ST_TRUNCATED],
			status_seen[ST_OVER_LIMIT], "count mismatch", status_seen[ST_MISMATCH],
			status_seen[ST_FLAT]);
		if (fail_count == 0 && awaited_reports.size() == 0)
			$display("gray_image_stream_checker verification clean");
		else
			$display("gray_image_stream_checker verification failed");
		$finish;
	end

endmodule

// ===== gray_image_stream_checker.f =====
rtl/core/gisc_pkg.sv
rtl/core/gisc_div.sv
rtl/core/gisc_dp.sv
rtl/core/gisc_ctrl.sv
rtl/core/gray_image_stream_checker.sv
verif/gray_image_stream_checker_tb.sv
